>>> rtl/core/ffrm_pkg.sv
// Shared types and constants for the fixed frame receiver and matcher.
`default_nettype none
package ffrm_pkg;

	localparam logic [7:0] START_BYTE    = 8'h5A;
	localparam logic [7:0] END_BYTE      = 8'hA5;
	localparam logic [7:0] ANY_CHECK     = 8'hFF;
	localparam logic [7:0] RESPONSE_BIT  = 8'h80;
	localparam logic [7:0] VERSION_VALUE = 8'h00;

	localparam logic [3:0] POS_HUNT    = 4'd0;
	localparam logic [3:0] POS_VERSION = 4'd1;
	localparam logic [3:0] POS_SOURCE  = 4'd2;
	localparam logic [3:0] POS_DEST    = 4'd3;
	localparam logic [3:0] POS_PAY_LO  = 4'd4;
	localparam logic [3:0] POS_PAY_HI  = 4'd11;
	localparam logic [3:0] POS_CHECK   = 4'd12;
	localparam logic [3:0] POS_END     = 4'd13;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLASS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FUNCTION = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL  = 2'd3;

	typedef struct packed {
		logic [7:0] source;
		logic [7:0] class_byte;
		logic [7:0] function_byte;
		logic [7:0] channel;
	} cfg_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic        awaited_response;
		logic [63:0] payload;
		logic [7:0]  dest_id;
		logic [7:0]  source_id;
	} result_t;

endpackage
`default_nettype wire

>>> rtl/core/ffrm_in_stage.sv
// Input register stage that holds one accepted transfer until it is processed.
`default_nettype none
module ffrm_in_stage import ffrm_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_item,
	input  wire logic     advance,
	output logic          valid_s1,
	output in_item_t      item_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/ffrm_assembler.sv
// Frame assembly, checksum, version and end-byte checks, and response matching.
`default_nettype none
module ffrm_assembler import ffrm_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cfg_t     cfg,
	input  wire logic     valid_s1,
	input  wire in_item_t item_s1,
	input  wire logic     out_free,
	output logic          advance,
	output logic          res_valid,
	output result_t       res
);

	logic [3:0]  pos_q, pos_d;
	logic [7:0]  sum_q, sum_d;
	logic        version_ok_q, version_ok_d;
	logic [7:0]  source_q, source_d;
	logic [7:0]  dest_q, dest_d;
	logic [63:0] payload_q, payload_d;
	logic [7:0]  check_q, check_d;
	logic        armed_q, armed_d;
	logic        at_end;
	logic        hunting;
	logic        sum_ok;
	logic        frame_ok;
	logic        match;
	logic [7:0]  b;

	assign b       = item_s1.rx_byte;
	assign hunting = (pos_q == POS_HUNT) || (pos_q > POS_END);
	assign at_end  = !item_s1.mode && (pos_q == POS_END);
	assign advance = valid_s1 && (!at_end || out_free);

	assign sum_ok   = ((sum_q + check_q) == 8'h00) || (check_q == ANY_CHECK);
	assign frame_ok = (b == END_BYTE) && version_ok_q && sum_ok;
	assign match    = armed_q && (source_q == cfg.source)
		&& (payload_q[63:56] == cfg.class_byte)
		&& (payload_q[55:48] == (cfg.function_byte | RESPONSE_BIT))
		&& (payload_q[47:40] == cfg.channel);

	always_comb begin
		pos_d        = pos_q;
		sum_d        = sum_q;
		version_ok_d = version_ok_q;
		source_d     = source_q;
		dest_d       = dest_q;
		payload_d    = payload_q;
		check_d      = check_q;
		armed_d      = armed_q;
		res_valid    = 1'b0;
		res.source_id        = source_q;
		res.dest_id          = dest_q;
		res.payload          = payload_q;
		res.awaited_response = match;
		if (advance) begin
			if (item_s1.mode) begin
				armed_d = 1'b1;
			end else if (hunting) begin
				pos_d = (b == START_BYTE) ? POS_VERSION : POS_HUNT;
			end else if (pos_q == POS_END) begin
				pos_d = POS_HUNT;
				if (frame_ok) begin
					res_valid = 1'b1;
					if (match) begin
						armed_d = 1'b0;
					end
				end
			end else begin
				pos_d = pos_q + 4'd1;
				if (pos_q == POS_VERSION) begin
					version_ok_d = (b == VERSION_VALUE);
					sum_d        = 8'h00;
				end else if (pos_q == POS_SOURCE) begin
					source_d = b;
					sum_d    = sum_q + b;
				end else if (pos_q == POS_DEST) begin
					dest_d = b;
					sum_d  = sum_q + b;
				end else if (pos_q >= POS_PAY_LO && pos_q <= POS_PAY_HI) begin
					payload_d = {payload_q[55:0], b};
					sum_d     = sum_q + b;
				end else if (pos_q == POS_CHECK) begin
					check_d = b;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= POS_HUNT;
			sum_q        <= 8'h00;
			version_ok_q <= 1'b0;
			source_q     <= 8'h00;
			dest_q       <= 8'h00;
			payload_q    <= 64'h0;
			check_q      <= 8'h00;
			armed_q      <= 1'b0;
		end else begin
			pos_q        <= pos_d;
			sum_q        <= sum_d;
			version_ok_q <= version_ok_d;
			source_q     <= source_d;
			dest_q       <= dest_d;
			payload_q    <= payload_d;
			check_q      <= check_d;
			armed_q      <= armed_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/ffrm_out_reg.sv
// Result register that holds one frame result until the receiver takes it.
`default_nettype none
module ffrm_out_reg import ffrm_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    res_valid,
	input  wire result_t res,
	output logic         out_free,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      out_res
);

	logic out_valid_q;
	result_t res_q;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			res_q <= res;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/fixed_frame_receiver_matcher.sv
// Top level of the fixed frame receiver and response matcher.
// Usage:
// The slave stream carries one item per transfer: s_tdata holds a received
// byte and s_tuser is set for an arm item, which starts a wait for a response.
// Bytes are assembled into 14-byte frames that open with 0x5A and close with
// 0xA5; each frame that passes the version, checksum and end checks yields
// one master transfer with its source, destination and payload. m_tuser marks
// the first valid frame that matches the armed wait on the configured source,
// class, function with the response bit set, and channel.
// The write port sets the four match registers; the user must use it only while
// idle, which the block does not enforce. A transfer is registered on entry and
// each result again at the output; one item is taken every cycle unless a
// closing byte waits for the output register. When the receiver stalls, one
// result waits in the output register and the input keeps taking items until
// the next closing byte needs that register. Reset returns the block to hunting
// for a start byte, clears the wait and sets all match registers to zero.
`default_nettype none
module fixed_frame_receiver_matcher import ffrm_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [7:0]           s_tdata,   // rx_byte
	input  wire logic                 s_tuser,   // mode
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [79:0]               m_tdata,   // source_id, dest_id, payload
	output logic                      m_tuser,   // awaited_response
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_wdata
);

	cfg_t     cfg_q;
	in_item_t in_item;
	in_item_t item_s1;
	logic     valid_s1;
	logic     advance;
	logic     out_free;
	logic     res_valid;
	result_t  res;
	result_t  out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOURCE:   cfg_q.source        <= cfg_wdata;
				REG_CLASS:    cfg_q.class_byte    <= cfg_wdata;
				REG_FUNCTION: cfg_q.function_byte <= cfg_wdata;
				REG_CHANNEL:  cfg_q.channel       <= cfg_wdata;
				default:      cfg_q               <= cfg_q;
			endcase
		end
	end

	assign in_item.mode    = s_tuser;
	assign in_item.rx_byte = s_tdata;

	ffrm_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ffrm_assembler u_assembler (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.out_free  (out_free),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res)
	);

	ffrm_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_free  (out_free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {out_res.payload, out_res.dest_id, out_res.source_id};
	assign m_tuser = out_res.awaited_response;

endmodule
`default_nettype wire

>>> dv/fixed_frame_receiver_matcher_tb.sv
// Testbench for the fixed frame receiver and matcher, checked by a behavioral frame decoder.
module fixed_frame_receiver_matcher_tb;
	import ffrm_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 225;

	typedef enum {
		FRAME_GOOD,
		FRAME_ANY_CHECK,
		FRAME_BAD_VERSION,
		FRAME_BAD_END,
		FRAME_BAD_CHECK,
		FRAME_CUT
	} frame_kind_e;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;    // rx_byte
	logic                 s_tuser = 1'b0;  // mode
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [79:0]          m_tdata;         // source_id, dest_id, payload
	logic                 m_tuser;         // awaited_response
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_wdata = '0;

	// Decoder state mirrored from the block.
	cfg_t       match_cfg;
	logic [3:0] rx_pos;
	logic [7:0] rx_sum;
	logic       rx_ver_ok;
	logic [7:0] rx_src;
	logic [7:0] rx_dst;
	logic [63:0] rx_payload;
	logic [7:0] rx_chk;
	logic       wait_armed;
	result_t    expected_frames[$];
	result_t    oldest_frame;

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	int cycles = 0;
	int mismatches = 0;
	int items_taken = 0;
	int frames_seen = 0;
	int frames_dropped = 0;
	int flagged = 0;

	fixed_frame_receiver_matcher u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic reset_decoder();
		match_cfg = '0;
		rx_pos = POS_HUNT;
		rx_sum = '0;
		rx_ver_ok = 1'b0;
		rx_src = '0;
		rx_dst = '0;
		rx_payload = '0;
		rx_chk = '0;
		wait_armed = 1'b0;
	endtask

	task automatic decode_item(input logic mode, input logic [7:0] b);
		result_t    r;
		logic [7:0] total;
		logic       sum_ok;
		logic       hit;
		if (mode) begin
			wait_armed = 1'b1;
		end else if (rx_pos == POS_HUNT || rx_pos > POS_END) begin
			rx_pos = (b == START_BYTE) ? POS_VERSION : POS_HUNT;
		end else begin
			if (rx_pos == POS_VERSION) begin
				rx_ver_ok = (b == VERSION_VALUE);
				rx_sum = '0;
			end else if (rx_pos == POS_SOURCE) begin
				rx_src = b;
				rx_sum += b;
			end else if (rx_pos == POS_DEST) begin
				rx_dst = b;
				rx_sum += b;
			end else if (rx_pos <= POS_PAY_HI) begin
				rx_payload = {rx_payload[55:0], b};
				rx_sum += b;
			end else if (rx_pos == POS_CHECK) begin
				rx_chk = b;
			end
			if (rx_pos < POS_END) begin
				rx_pos += 4'd1;
			end else begin
				rx_pos = POS_HUNT;
				total = rx_sum + rx_chk;
				sum_ok = (total == 8'h00) || (rx_chk == ANY_CHECK);
				if (b != END_BYTE || !rx_ver_ok || !sum_ok) begin
					frames_dropped++;
				end else begin
					hit = wait_armed && rx_src == match_cfg.source &&
						rx_payload[63:56] == match_cfg.class_byte &&
						rx_payload[55:48] == (match_cfg.function_byte | RESPONSE_BIT) &&
						rx_payload[47:40] == match_cfg.channel;
					if (hit) begin
						wait_armed = 1'b0;
					end
					r.source_id = rx_src;
					r.dest_id = rx_dst;
					r.payload = rx_payload;
					r.awaited_response = hit;
					expected_frames.push_back(r);
				end
			end
		end
	endtask

	// Results leaving at this edge stem from earlier inputs, so they are checked first.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			frames_seen++;
			if (expected_frames.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected frame: data %h flag %b", m_tdata, m_tuser);
				end
			end else begin
				oldest_frame = expected_frames.pop_front();
				if (oldest_frame.awaited_response) begin
					flagged++;
				end
				if (m_tdata[7:0] !== oldest_frame.source_id ||
						m_tdata[15:8] !== oldest_frame.dest_id ||
						m_tdata[79:16] !== oldest_frame.payload ||
						m_tuser !== oldest_frame.awaited_response) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("frame mismatch: expected src %h dst %h payload %h flag %b",
							oldest_frame.source_id, oldest_frame.dest_id,
							oldest_frame.payload, oldest_frame.awaited_response);
						$display("                got      src %h dst %h payload %h flag %b",
							m_tdata[7:0], m_tdata[15:8], m_tdata[79:16], m_tuser);
					end
				end
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			items_taken++;
			decode_item(s_tuser, s_tdata);
		end
	end

	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d frames still awaited.",
				cycles, expected_frames.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_item(input logic mode, input logic [7:0] b);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'($urandom);
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [7:0] src, input logic [7:0] dst,
			input logic [63:0] pay, input frame_kind_e kind, input int arm_at);
		logic [7:0] frame_bytes [14];
		logic [7:0] sum;
		int         k;
		int         len;
		sum = src + dst;
		for (k = 0; k < 8; k++) begin
			sum += pay[63-8*k -: 8];
			frame_bytes[4+k] = pay[63-8*k -: 8];
		end
		frame_bytes[0] = START_BYTE;
		frame_bytes[1] = (kind == FRAME_BAD_VERSION) ? 8'($urandom_range(1, 255)) : VERSION_VALUE;
		frame_bytes[2] = src;
		frame_bytes[3] = dst;
		frame_bytes[12] = 8'h00 - sum;
		if (kind == FRAME_ANY_CHECK) begin
			frame_bytes[12] = ANY_CHECK;
		end else if (kind == FRAME_BAD_CHECK) begin
			frame_bytes[12] += 8'($urandom_range(1, 255));
		end
		frame_bytes[13] = END_BYTE;
		if (kind == FRAME_BAD_END) begin
			frame_bytes[13] = END_BYTE ^ 8'($urandom_range(1, 255));
		end
		len = (kind == FRAME_CUT) ? $urandom_range(2, 12) : 14;
		for (k = 0; k < len; k++) begin
			if (k == arm_at) begin
				send_item(1'b1, 8'($urandom));
			end
			send_item(1'b0, frame_bytes[k]);
		end
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_frames.size() != 0) begin
			@(posedge clk);
		end
		repeat (6) @(negedge clk);
	endtask

	task automatic write_match_regs(input cfg_t v);
		cfg_we <= 1'b1;
		cfg_index <= REG_SOURCE;
		cfg_wdata <= v.source;
		@(negedge clk);
		cfg_index <= REG_CLASS;
		cfg_wdata <= v.class_byte;
		@(negedge clk);
		cfg_index <= REG_FUNCTION;
		cfg_wdata <= v.function_byte;
		@(negedge clk);
		cfg_index <= REG_CHANNEL;
		cfg_wdata <= v.channel;
		@(negedge clk);
		cfg_we <= 1'b0;
		match_cfg = v;
	endtask

	// An arm inside the first frame leaves it intact; the second copy finds the wait already used.
	task automatic test_directed_frames();
		write_match_regs('{source: 8'hFF, class_byte: 8'h00, function_byte: 8'h7F,
			channel: 8'hFF});
		send_item(1'b1, 8'h00);
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'hFF);
		send_frame(8'hFF, 8'h00, 64'h00FF_FF00_FF00_FF00, FRAME_ANY_CHECK, 5);
		send_frame(8'hFF, 8'h00, 64'h00FF_FF00_FF00_FF00, FRAME_GOOD, -1);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
			input cfg_t regs, input int n_items);
		int          stop_at;
		int          pick;
		logic [7:0]  src;
		logic [63:0] pay;
		frame_kind_e kind;
		wait_idle();
		write_match_regs(regs);
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		stop_at = items_taken + n_items;
		while (items_taken < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				send_item(1'b1, 8'($urandom));
			end else if (pick < 18) begin
				send_item(1'b0, ($urandom_range(3) == 0) ? START_BYTE : 8'($urandom));
			end else begin
				src = 8'($urandom);
				pay = {$urandom, $urandom};
				if ($urandom_range(99) < 40) begin
					src = match_cfg.source;
					pay[63:40] = {match_cfg.class_byte, match_cfg.function_byte | RESPONSE_BIT,
						match_cfg.channel};
					if ($urandom_range(99) < 30) begin
						pay[63-8*$urandom_range(2) -: 8] ^= 8'($urandom_range(1, 255));
					end
				end
				pick = $urandom_range(99);
				kind = (pick < 50) ? FRAME_GOOD :
					(pick < 62) ? FRAME_ANY_CHECK :
					(pick < 72) ? FRAME_BAD_VERSION :
					(pick < 82) ? FRAME_BAD_END :
					(pick < 92) ? FRAME_BAD_CHECK : FRAME_CUT;
				send_frame(src, 8'($urandom), pay, kind,
					($urandom_range(9) == 0) ? $urandom_range(1, 13) : -1);
			end
		end
	endtask

	// The output is held off long enough for the block to fill and refuse input.
	task automatic test_output_backpressure();
		int k;
		wait_idle();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_request = 400;
		for (k = 0; k < 8; k++) begin
			send_frame(8'($urandom), 8'($urandom), {$urandom, $urandom}, FRAME_GOOD, -1);
		end
	endtask

	initial begin
		reset_decoder();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_frames();
		test_random_traffic(0, 0, '{default: 8'h00}, PHASE_ITEMS);
		test_random_traffic(69, 0, '{default: 8'hFF}, PHASE_ITEMS);
		test_random_traffic(0, 69, cfg_t'($urandom), PHASE_ITEMS);
		test_random_traffic(19, 19, cfg_t'($urandom), PHASE_ITEMS);
		test_output_backpressure();
		receiver_stall_pct = 0;
		wait_idle();
		repeat (10) @(posedge clk);
		$display("Took %0d input transfers under four idle mixes and one long output hold.",
			items_taken);
		$display("Frames delivered %0d, flagged as awaited %0d, dropped as bad %0d.",
			frames_seen, flagged, frames_dropped);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
